// ----- rtl/assert_macros.svh -----
// assertion macros shared by the delay line modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("never");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ----- rtl/sfdl_pkg.sv -----
// package for the smoothed feedback delay line: constants, codes, command types
// no dependencies
`default_nettype none
package sfdl_pkg;
  localparam int STORE_DEPTH_DEF = 131072;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int IO_BITS = 24;
  localparam int MOD_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TIME = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FB = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WET = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF = 3'd5;

  // one datapath step per controller state
  typedef struct packed {
    logic clr;     // clearing pass write
    logic load;    // capture input, compute target
    logic smooth;  // smoother update
    logic scale;   // delay in samples
    logic rd0;     // read first tap
    logic rd1;     // read second tap
    logic interp;  // interpolate
    logic finish;  // store write, delayed sample, advance
    logic emit;    // mix into the result register
  } sfdl_cmd_t;

  typedef struct packed {
    logic clr_done;
  } sfdl_sts_t;
endpackage
`default_nettype wire

// ----- rtl/sfdl_if.sv -----
// valid/ready stream interfaces for samples, results and configuration
// depends on sfdl_pkg
`default_nettype none
interface sfdl_in_if;
  logic valid;
  logic ready;
  logic signed [sfdl_pkg::IO_BITS-1:0] audio_in;
  logic signed [sfdl_pkg::MOD_BITS-1:0] modulation;
  modport source (output valid, audio_in, modulation, input ready);
  modport sink (input valid, audio_in, modulation, output ready);
endinterface

interface sfdl_out_if;
  logic valid;
  logic ready;
  logic signed [sfdl_pkg::IO_BITS-1:0] audio_out;
  modport source (output valid, audio_out, input ready);
  modport sink (input valid, audio_out, output ready);
endinterface

interface sfdl_cfg_if;
  logic valid;
  logic ready;
  logic [sfdl_pkg::CFG_IDX_BITS-1:0] index;
  logic [sfdl_pkg::CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/smoothed_feedback_delay_line.sv -----
// the input transfer loads the sample; the smooth, scale, rd0, rd1, interp, finish
// and out steps follow in turn around the single store read port, and no new sample
// is taken before the result is emitted; a result still waiting holds the sequence
// at its last step until it is taken; after reset a clearing pass writes zero to
// every store entry, during which no sample is taken; configuration writes are taken at any time
`default_nettype none
module smoothed_feedback_delay_line #(
  parameter int STORE_DEPTH = sfdl_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  sfdl_in_if.sink in_ch,
  sfdl_out_if.source out_ch,
  sfdl_cfg_if.sink cfg
);
  import sfdl_pkg::*;
  sfdl_cmd_t cmd;
  sfdl_sts_t sts;

  assign cfg.ready = 1'b1;

  sfdl_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd
  );

  sfdl_datapath #(.STORE_DEPTH(STORE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .cfg_we(cfg.valid), .cfg_index(cfg.index),
    .cfg_data(cfg.data), .audio_in(in_ch.audio_in), .modulation(in_ch.modulation),
    .audio_out(out_ch.audio_out)
  );
endmodule
`default_nettype wire

// ----- rtl/sfdl_ctrl.sv -----
// controller: clearing pass after reset, then a fixed step sequence per sample
// depends on sfdl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sfdl_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire sfdl_pkg::sfdl_sts_t sts,
  output sfdl_pkg::sfdl_cmd_t cmd
);
  import sfdl_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SMOOTH, S_SCALE, S_RD0, S_RD1, S_INTERP, S_FINISH, S_OUT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.clr = (state == S_CLR);
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.smooth = (state == S_SMOOTH);
    cmd.scale = (state == S_SCALE);
    cmd.rd0 = (state == S_RD0);
    cmd.rd1 = (state == S_RD1);
    cmd.interp = (state == S_INTERP);
    cmd.finish = (state == S_FINISH);
    cmd.emit = (state == S_OUT) && (!out_valid || out_ready);
  end

  // state and registered output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLR: if (sts.clr_done) state <= S_IDLE;
        S_IDLE: if (in_valid) state <= S_SMOOTH;
        S_SMOOTH: state <= S_SCALE;
        S_SCALE: state <= S_RD0;
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_INTERP;
        S_INTERP: state <= S_FINISH;
        S_FINISH: state <= S_OUT;
        S_OUT: if (cmd.emit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_no_accept_in_clear, clk, rst, (state == S_CLR) |-> !in_ready)
  `ASSERT_IMPL(a_finish_then_out, clk, rst, cmd.finish |=> (state == S_OUT))
  `ASSERT_IMPL(a_load_from_idle, clk, rst, cmd.load |=> (state == S_SMOOTH))
  `ASSERT_IMPL(a_out_held, clk, rst, (out_valid && !out_ready) |=> out_valid)
endmodule
`default_nettype wire

// ----- rtl/sfdl_datapath.sv -----
// datapath: registers, smoother, delay scale, store, interpolation and mix
// depends on sfdl_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module sfdl_datapath #(
  parameter int STORE_DEPTH = sfdl_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = sfdl_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sfdl_pkg::sfdl_cmd_t cmd,
  output sfdl_pkg::sfdl_sts_t sts,
  input  wire logic cfg_we,
  input  wire logic [sfdl_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [sfdl_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  wire logic signed [sfdl_pkg::IO_BITS-1:0] audio_in,
  input  wire logic signed [sfdl_pkg::MOD_BITS-1:0] modulation,
  output logic signed [sfdl_pkg::IO_BITS-1:0] audio_out
);
  import sfdl_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = AW + 16;
  localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);
  localparam logic [47:0] CAP = 48'(STORE_DEPTH - 1) << 16;
  localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'sd1 <<< (SB-1)) - 1);
  localparam logic signed [SB+1:0] SMIN = -SMAX - 1;

  // configuration registers
  logic mode;
  logic [23:0] time_tgt;
  logic [15:0] fb_amt, wet_reg, coef;
  logic [17:0] rate;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0; time_tgt <= '0; fb_amt <= '0;
      wet_reg <= 16'd16384; rate <= 18'd48000; coef <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE: mode <= cfg_data[0];
        REG_TIME: time_tgt <= cfg_data;
        REG_FB: fb_amt <= cfg_data[15:0];
        REG_WET: wet_reg <= cfg_data[15:0];
        REG_RATE: rate <= cfg_data[17:0];
        REG_COEF: coef <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // state and working registers
  logic [AW-1:0] wpos, clr_addr;
  logic signed [SB-1:0] fb_sample, x0, x1, delayed;
  logic [31:0] smoothed;
  logic signed [23:0] x_in;
  logic [31:0] target32;
  logic [47:0] delay_q16;
  logic [PW-1:0] rpos;
  logic clr_busy;

  // delay target: chorus from modulation in mode 1, else the time register
  logic signed [33:0] mprod;
  logic [23:0] tgt24;
  assign mprod = 34'sd33554 * 34'(modulation);
  assign tgt24 = mode ? 24'(34'sd50332 + (mprod >>> 15)) : time_tgt;

  // smoother
  logic signed [33:0] diff;
  logic signed [50:0] sprod;
  assign diff = $signed({2'b0, target32}) - $signed({2'b0, smoothed});
  assign sprod = $signed({35'b0, coef}) * 51'(diff);

  // delay scale
  logic [49:0] dprod;
  assign dprod = smoothed * rate;

  // read position
  logic [PW:0] rraw;
  logic [PW-1:0] rmod;
  assign rraw = {1'b0, wpos, 16'b0} - (PW+1)'(delay_q16) - (PW+1)'(17'h10000);
  assign rmod = rraw[PW] ? rraw[PW-1:0] + PW'(STORE_DEPTH) * PW'(65536) : rraw[PW-1:0];

  logic [AW-1:0] i0, i1;
  assign i0 = rpos[PW-1:16];
  assign i1 = (i0 == LAST) ? '0 : i0 + 1'b1;

  // first tap addressed straight from the new position, second from the register
  logic [AW-1:0] rd_addr;
  assign rd_addr = cmd.rd0 ? rmod[PW-1:16] : i1;

  // memory
  logic signed [SB-1:0] mem [STORE_DEPTH];
  logic signed [SB-1:0] rdata;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic signed [SB-1:0] mem_wd;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[rd_addr];
  end

  // interpolation
  logic signed [SB+17:0] iprod;
  logic signed [SB-1:0] dly_w;
  assign iprod = (SB+18)'($signed({x1[SB-1], x1}) - $signed({x0[SB-1], x0}))
                 * $signed({{SB+1{1'b0}}, rpos[15:0]});
  assign dly_w = SB'((SB+18)'(x0) + (iprod >>> 16));

  // feedback and store value
  logic [15:0] fbc, wet;
  logic [31:0] mfb_raw;
  logic [15:0] mfb;
  logic signed [SB+16:0] fprod;
  logic signed [SB+1:0] stored_w;
  logic signed [SB-1:0] stored;
  assign fbc = (fb_amt > 16'd32768) ? 16'd32768 : fb_amt;
  assign mfb_raw = fbc * 32'd31130 + 32'd16384;
  assign mfb = mfb_raw[30:15];
  assign fprod = (SB+17)'(fb_sample) * $signed({{SB+1{1'b0}}, mfb});
  assign stored_w = (SB+2)'(x_in) + (SB+2)'(fprod >>> 15);
  assign stored = (stored_w > SMAX) ? SB'(SMAX) : (stored_w < SMIN) ? SB'(SMIN)
                  : SB'(stored_w);

  // mix
  logic signed [SB+18:0] mix_sum;
  logic signed [SB+3:0] mix_sh;
  logic signed [SB-1:0] mixed;
  assign wet = (wet_reg > 16'd32768) ? 16'd32768 : wet_reg;
  assign mix_sum = (SB+19)'(x_in) * $signed({{SB+2{1'b0}}, 17'(17'd32768 - wet)})
                 + (SB+19)'(delayed) * $signed({{SB+2{1'b0}}, 1'b0, wet});
  assign mix_sh = (SB+4)'(mix_sum >>> 15);
  assign mixed = (mix_sh > (SB+4)'(SMAX)) ? SB'(SMAX)
               : (mix_sh < (SB+4)'(SMIN)) ? SB'(SMIN) : SB'(mix_sh);

  assign mem_we = cmd.clr || cmd.finish;
  assign mem_wa = cmd.clr ? clr_addr : wpos;
  assign mem_wd = cmd.clr ? '0 : stored;
  assign sts.clr_done = cmd.clr && (clr_addr == LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos <= '0; fb_sample <= '0; smoothed <= '0; clr_addr <= '0; clr_busy <= 1'b1;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST) clr_busy <= 1'b0;
      end
      if (cmd.smooth) smoothed <= 32'($signed({2'b0, smoothed}) + 34'(sprod >>> 16));
      if (cmd.finish) begin
        fb_sample <= dly_w;
        wpos <= (wpos == LAST) ? '0 : wpos + 1'b1;
      end
    end
  end

  // second tap lands in x1 at interp; delayed sample registered at finish
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_in <= audio_in;
      target32 <= {tgt24, 8'b0};
    end
    if (cmd.scale) delay_q16 <= (48'(dprod[49:16]) > CAP) ? CAP : 48'(dprod[49:16]);
    if (cmd.rd0) rpos <= rmod;
    if (cmd.rd1) x0 <= rdata;
    if (cmd.interp) begin
      x1 <= rdata;
    end
    if (cmd.finish) delayed <= dly_w;
    if (cmd.emit) audio_out <= 24'(mixed);
  end

  `ASSERT_IMPL(a_clear_no_sample, clk, rst, clr_busy |-> !cmd.load)
  `ASSERT_IMPL(a_wpos_step, clk, rst, (cmd.finish && wpos != LAST) |=> (wpos == $past(wpos) + 1'b1))
  `ASSERT_IMPL(a_wpos_wrap, clk, rst, (cmd.finish && wpos == LAST) |=> (wpos == '0))
  `ASSERT_IMPL(a_rpos_range, clk, rst, cmd.rd1 |-> (i0 <= LAST))
endmodule
`default_nettype wire
